@@ rtl/ald_pkg.sv @@
// shared constants and types of the antialiased line drawer
`default_nettype none

package ald_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int ACC_BITS_DEF   = 16;

    // field and register widths
    localparam int COLOR_BITS = 9;
    localparam int BASE_BITS  = 8;
    localparam int LEVEL_BITS = 9;
    localparam int IBITS_BITS = 4;

    // register port
    localparam int ADDR_BITS    = 4;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_BASE_COLOR     = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_NUM_LEVELS     = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_INTENSITY_BITS = REG_IDX_BITS'(2);

    localparam logic [BASE_BITS-1:0]  BASE_COLOR_RST     = BASE_BITS'(0);
    localparam logic [LEVEL_BITS-1:0] NUM_LEVELS_RST     = LEVEL_BITS'(256);
    localparam logic [IBITS_BITS-1:0] INTENSITY_BITS_RST = IBITS_BITS'(8);

    // command codes
    localparam logic CMD_START = 1'b0;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

@@ rtl/ald_if.sv @@
// valid/ready channel interfaces for commands and pixels
`default_nettype none

interface ald_in_if #(
    parameter int COORD_BITS = ald_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (
        output valid, cmd, x_start, y_start, x_end, y_end,
        input  ready
    );
    modport sink (
        input  valid, cmd, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

interface ald_out_if #(
    parameter int COORD_BITS = ald_pkg::COORD_BITS_DEF
) ();
    import ald_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS:0]   pix_x;
    logic signed [COORD_BITS:0]   pix_y;
    logic [COLOR_BITS-1:0]        pix_color;
    logic                         item_last;
    logic                         line_done;

    modport source (
        output valid, pix_x, pix_y, pix_color, item_last, line_done,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, pix_color, item_last, line_done,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/antialiased_line_drawer.sv @@
// top level of the antialiased line drawer: register port, sequencer, pixel output
`default_nettype none

// Draws one antialiased line at a time with Wu's scheme. A start word takes two
// endpoints, orders them top to bottom and emits the upper endpoint in the base
// color in the cycle after it is accepted. Horizontal, vertical and diagonal
// lines are then ready for advances at once; any other slope runs the
// restoring divider for the error step, and the command channel is held not
// ready after the start word until the quotient is loaded. Straight lines
// emit one pixel per advance, so they sustain one advance per cycle while
// the output is taken; sloped lines emit a pixel pair, and the single output
// register holds the next advance off until the second pixel is loaded. The
// closing advance of a sloped line emits the far endpoint unweighted. An
// output word that waits to be taken does not block the next command word
// when it is taken in the same cycle. Configuration goes through the register
// port (base color at 0x0, level count at 0x4, intensity bits at 0x8) and
// should change only while idle.

module antialiased_line_drawer #(
    parameter int COORD_BITS = ald_pkg::COORD_BITS_DEF,
    parameter int ACC_BITS   = ald_pkg::ACC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ald_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [ald_pkg::DATA_BITS-1:0]  pwdata,
    output logic [ald_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    ald_in_if.sink                         i_in,
    ald_out_if.source                      o_out
);
    import ald_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int PW  = COORD_BITS + 1;
    localparam int SHW = $clog2(ACC_BITS + 1);
    localparam int WW  = (ACC_BITS > COLOR_BITS) ? ACC_BITS : COLOR_BITS;

    // line kinds
    localparam logic [2:0] K_IDLE = 3'd0;
    localparam logic [2:0] K_HOR  = 3'd1;
    localparam logic [2:0] K_VER  = 3'd2;
    localparam logic [2:0] K_DIAG = 3'd3;
    localparam logic [2:0] K_YMAJ = 3'd4;
    localparam logic [2:0] K_XMAJ = 3'd5;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PAIR = 2'd2;

    // configuration registers
    logic [BASE_BITS-1:0]  r_base;
    logic [LEVEL_BITS-1:0] r_levels;
    logic [IBITS_BITS-1:0] r_ibits;

    // line state
    logic [1:0]            r_state, n_state;
    logic [2:0]            r_kind, n_kind;
    logic                  r_left, n_left;
    logic signed [CW-1:0]  r_cur_x, n_cur_x;
    logic signed [CW-1:0]  r_cur_y, n_cur_y;
    logic signed [CW-1:0]  r_end_x, n_end_x;
    logic signed [CW-1:0]  r_end_y, n_end_y;
    logic [CW-1:0]         r_steps, n_steps;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic [ACC_BITS-1:0]   r_step, n_step;

    // output register and the held second pixel of a pair
    logic                  r_ov, n_ov;
    logic signed [PW-1:0]  r_o_x, n_o_x;
    logic signed [PW-1:0]  r_o_y, n_o_y;
    logic [COLOR_BITS-1:0] r_o_color, n_o_color;
    logic                  r_o_last, n_o_last;
    logic                  r_o_done, n_o_done;
    logic signed [PW-1:0]  r_p2_x, n_p2_x;
    logic signed [PW-1:0]  r_p2_y, n_p2_y;
    logic [COLOR_BITS-1:0] r_p2_color, n_p2_color;

    // divider hookup
    logic                  div_start;
    logic [CW-1:0]         div_num;
    logic [CW-1:0]         div_den;
    logic [ACC_BITS-1:0]   div_quot;
    t_div_stat             div_stat;

    // handshake
    logic out_free;
    logic in_fire;
    logic cfg_wr;

    // start decode
    logic                 swap;
    logic signed [CW-1:0] sx0, sy0, sx1, sy1;
    logic signed [PW-1:0] dx_w, dy_w, adx_w;
    logic [CW-1:0]        adx, ady;
    logic                 y_major;
    logic [2:0]           st_kind;

    // advance datapath
    logic signed [CW-1:0]  x_stp, y_stp;
    logic signed [PW-1:0]  dir_w;
    logic [ACC_BITS-1:0]   acc_sum;
    logic                  acc_wrap;
    logic [SHW-1:0]        sh;
    logic [WW-1:0]         w_wide;
    logic [COLOR_BITS-1:0] w9, cmask, col_a, col_b, col_base;
    logic signed [CW-1:0]  wx, wy;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && !div_stat.busy && out_free;
    assign in_fire  = i_in.valid && i_in.ready;

    // ---- register port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_COLOR_RST;
            r_levels <= NUM_LEVELS_RST;
            r_ibits  <= INTENSITY_BITS_RST;
        end else if (cfg_wr) begin
            case (paddr[ADDR_BITS-1:2])
                REG_BASE_COLOR:     r_base   <= pwdata[BASE_BITS-1:0];
                REG_NUM_LEVELS:     r_levels <= pwdata[LEVEL_BITS-1:0];
                REG_INTENSITY_BITS: r_ibits  <= pwdata[IBITS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_BITS-1:2])
            REG_BASE_COLOR:     prdata = DATA_BITS'(r_base);
            REG_NUM_LEVELS:     prdata = DATA_BITS'(r_levels);
            REG_INTENSITY_BITS: prdata = DATA_BITS'(r_ibits);
            default:            prdata = '0;
        endcase
    end

    // ---- start decode: order endpoints top to bottom, classify the slope ----
    always_comb begin
        swap  = i_in.y_start > i_in.y_end;
        sx0   = swap ? i_in.x_end   : i_in.x_start;
        sy0   = swap ? i_in.y_end   : i_in.y_start;
        sx1   = swap ? i_in.x_start : i_in.x_end;
        sy1   = swap ? i_in.y_start : i_in.y_end;
        dx_w  = {sx1[CW-1], sx1} - {sx0[CW-1], sx0};
        dy_w  = {sy1[CW-1], sy1} - {sy0[CW-1], sy0};
        adx_w = dx_w[PW-1] ? -dx_w : dx_w;
        adx   = adx_w[CW-1:0];
        ady   = dy_w[CW-1:0];
        // major axis length is the step count, minor over major the error step
        y_major = ady >= adx;
        div_num = y_major ? adx : ady;
        div_den = y_major ? ady : adx;
        if (ady == '0) begin
            st_kind = (adx == '0) ? K_IDLE : K_HOR;
        end else if (adx == '0) begin
            st_kind = K_VER;
        end else if (adx == ady) begin
            st_kind = K_DIAG;
        end else if (ady > adx) begin
            st_kind = K_YMAJ;
        end else begin
            st_kind = K_XMAJ;
        end
    end

    // ---- advance datapath ----
    always_comb begin
        x_stp    = r_left ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
        y_stp    = r_cur_y + CW'(1);
        dir_w    = r_left ? '1 : PW'(1);
        acc_sum  = r_acc + r_step;
        acc_wrap = acc_sum <= r_acc;
        // weight is the top intensity_bits of the accumulator
        sh       = (SHW'(r_ibits) >= SHW'(ACC_BITS)) ? '0 : SHW'(ACC_BITS) - SHW'(r_ibits);
        w_wide   = WW'(acc_sum) >> sh;
        w9       = w_wide[COLOR_BITS-1:0];
        cmask    = COLOR_BITS'(r_levels) - COLOR_BITS'(1);
        col_base = COLOR_BITS'(r_base);
        col_a    = col_base + w9;
        col_b    = col_base + (w9 ^ cmask);
        if (r_kind == K_YMAJ) begin
            wx = acc_wrap ? x_stp : r_cur_x;
            wy = y_stp;
        end else begin
            wx = x_stp;
            wy = acc_wrap ? y_stp : r_cur_y;
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_left     = r_left;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_end_x    = r_end_x;
        n_end_y    = r_end_y;
        n_steps    = r_steps;
        n_acc      = r_acc;
        n_step     = r_step;
        n_ov       = r_ov && !o_out.ready;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_color  = r_o_color;
        n_o_last   = r_o_last;
        n_o_done   = r_o_done;
        n_p2_x     = r_p2_x;
        n_p2_y     = r_p2_y;
        n_p2_color = r_p2_color;
        div_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.cmd == CMD_START) begin
                        // new line, any current one is dropped
                        n_cur_x   = sx0;
                        n_cur_y   = sy0;
                        n_end_x   = sx1;
                        n_end_y   = sy1;
                        n_left    = dx_w[PW-1];
                        n_steps   = div_den;
                        n_acc     = '0;
                        n_step    = '0;
                        n_kind    = st_kind;
                        n_ov      = 1'b1;
                        n_o_x     = {sx0[CW-1], sx0};
                        n_o_y     = {sy0[CW-1], sy0};
                        n_o_color = col_base;
                        n_o_last  = 1'b1;
                        n_o_done  = st_kind == K_IDLE;
                        if (st_kind inside {K_YMAJ, K_XMAJ}) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end else if (r_kind == K_IDLE || r_steps == '0) begin
                        // advance with no line: nothing out
                        n_kind = K_IDLE;
                    end else if (r_kind inside {K_HOR, K_VER, K_DIAG}) begin
                        if (r_kind != K_VER) begin
                            n_cur_x = x_stp;
                        end
                        if (r_kind != K_HOR) begin
                            n_cur_y = y_stp;
                        end
                        n_steps   = r_steps - CW'(1);
                        n_ov      = 1'b1;
                        n_o_x     = (r_kind != K_VER) ? {x_stp[CW-1], x_stp}
                                                      : {r_cur_x[CW-1], r_cur_x};
                        n_o_y     = (r_kind != K_HOR) ? {y_stp[CW-1], y_stp}
                                                      : {r_cur_y[CW-1], r_cur_y};
                        n_o_color = col_base;
                        n_o_last  = 1'b1;
                        n_o_done  = r_steps == CW'(1);
                        if (r_steps == CW'(1)) begin
                            n_kind = K_IDLE;
                        end
                    end else if (r_steps == CW'(1)) begin
                        // closing step of a sloped line lands on the far endpoint
                        n_steps   = '0;
                        n_kind    = K_IDLE;
                        n_ov      = 1'b1;
                        n_o_x     = {r_end_x[CW-1], r_end_x};
                        n_o_y     = {r_end_y[CW-1], r_end_y};
                        n_o_color = col_base;
                        n_o_last  = 1'b1;
                        n_o_done  = 1'b1;
                    end else begin
                        // weighted pair across the minor axis
                        n_acc     = acc_sum;
                        n_cur_x   = wx;
                        n_cur_y   = wy;
                        n_steps   = r_steps - CW'(1);
                        n_ov      = 1'b1;
                        n_o_x     = {wx[CW-1], wx};
                        n_o_y     = {wy[CW-1], wy};
                        n_o_color = col_a;
                        n_o_last  = 1'b0;
                        n_o_done  = 1'b0;
                        n_p2_color = col_b;
                        if (r_kind == K_YMAJ) begin
                            n_p2_x = {wx[CW-1], wx} + dir_w;
                            n_p2_y = {wy[CW-1], wy};
                        end else begin
                            n_p2_x = {wx[CW-1], wx};
                            n_p2_y = {wy[CW-1], wy} + PW'(1);
                        end
                        n_state = S_PAIR;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_step  = div_quot;
                    n_state = S_IDLE;
                end
            end
            S_PAIR: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_x     = r_p2_x;
                    n_o_y     = r_p2_y;
                    n_o_color = r_p2_color;
                    n_o_last  = 1'b1;
                    n_o_done  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_IDLE;
            r_left  <= 1'b0;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_end_x <= '0;
            r_end_y <= '0;
            r_steps <= '0;
            r_acc   <= '0;
            r_step  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_end_x <= n_end_x;
            r_end_y <= n_end_y;
            r_steps <= n_steps;
            r_acc   <= n_acc;
            r_step  <= n_step;
            r_ov    <= n_ov;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_color  <= n_o_color;
        r_o_last   <= n_o_last;
        r_o_done   <= n_o_done;
        r_p2_x     <= n_p2_x;
        r_p2_y     <= n_p2_y;
        r_p2_color <= n_p2_color;
    end

    assign o_out.valid     = r_ov;
    assign o_out.pix_x     = r_o_x;
    assign o_out.pix_y     = r_o_y;
    assign o_out.pix_color = r_o_color;
    assign o_out.item_last = r_o_last;
    assign o_out.line_done = r_o_done;

    // error step divider, minor over major scaled by the accumulator width
    ald_div #(
        .N_BITS (COORD_BITS),
        .Q_BITS (ACC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

endmodule

`default_nettype wire

@@ rtl/ald_div.sv @@
// iterative restoring divider for the error step, one quotient bit per cycle
`default_nettype none

module ald_div #(
    parameter int N_BITS = ald_pkg::COORD_BITS_DEF,
    parameter int Q_BITS = ald_pkg::ACC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_num,
    input  logic [N_BITS-1:0] i_den,
    output logic [Q_BITS-1:0] o_quot,
    output ald_pkg::t_div_stat o_stat
);
    import ald_pkg::*;

    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic [N_BITS-1:0]   r_rem, n_rem;
    logic [N_BITS-1:0]   r_den;
    logic [Q_BITS-1:0]   r_quot;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [N_BITS:0] sh;
    logic [N_BITS:0] diff;
    logic            ge;

    // remainder stays below the divisor, so the shifted value is below twice it
    always_comb begin
        sh    = {r_rem, 1'b0};
        ge    = sh >= {1'b0, r_den};
        diff  = sh - {1'b0, r_den};
        n_rem = ge ? diff[N_BITS-1:0] : sh[N_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[Q_BITS-2:0], ge};
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ rtl/ald_checker.sv @@
// port-level checks of the antialiased line drawer and their bind
`default_nettype none

module ald_checker #(
    parameter int COORD_BITS = ald_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_in_cmd,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [COORD_BITS:0]           i_out_pix_x,
    input  logic [COORD_BITS:0]           i_out_pix_y,
    input  logic [ald_pkg::COLOR_BITS-1:0] i_out_color,
    input  logic                          i_out_last,
    input  logic                          i_out_done
);
    import ald_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pix_x)
            && $stable(i_out_pix_y) && $stable(i_out_color)
            && $stable(i_out_last) && $stable(i_out_done))
        else $error("output word changed while stalled");

    // a start always shows its first pixel in the next cycle
    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == CMD_START |=> i_out_valid)
        else $error("start word gave no pixel");

    // second pixel of a pair follows right after the first is taken
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last)
        else $error("pixel pair broken");

    // no command word taken while a pair is half delivered
    a_pair_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("command accepted inside a pixel pair");

endmodule

bind antialiased_line_drawer ald_checker #(
    .COORD_BITS (COORD_BITS)
) u_ald_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pix_x (o_out.pix_x),
    .i_out_pix_y (o_out.pix_y),
    .i_out_color (o_out.pix_color),
    .i_out_last  (o_out.item_last),
    .i_out_done  (o_out.line_done)
);

`default_nettype wire

@@ test/antialiased_line_drawer_tb.sv @@
// self-checking testbench of the antialiased line drawer: directed and random lines
module antialiased_line_drawer_tb;
    import ald_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int AB = ACC_BITS_DEF;
    localparam logic CMD_ADVANCE = ~CMD_START;

    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 204;   // words that draw something, per setting
    localparam int SETTLE_CYCLES   = 40;    // covers the divider and the output stage
    localparam int QUIET_LIMIT     = 5000;
    localparam int IDLE_PCT        = 29;
    localparam int N_PROBES        = 24;

    typedef enum logic [2:0] {
        LN_IDLE, LN_HORIZ, LN_VERT, LN_DIAG, LN_STEEP, LN_SHALLOW
    } line_kind_t;

    // how a command word is checked: by the predictor, as drawing nothing,
    // or against the single pixel typed into the row
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_t;

    typedef struct packed {
        check_t                check;
        logic                  cmd;
        logic signed [CB-1:0]  xs;
        logic signed [CB-1:0]  ys;
        logic signed [CB-1:0]  xe;
        logic signed [CB-1:0]  ye;
        logic signed [CB:0]    tx;
        logic signed [CB:0]    ty;
        logic [COLOR_BITS-1:0] tcolor;
        logic                  tdone;
    } line_word_t;

    typedef struct packed {
        logic signed [CB:0]    px;
        logic signed [CB:0]    py;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  done;
    } pixel_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    ald_in_if  #(.COORD_BITS(CB)) in_bus ();
    ald_out_if #(.COORD_BITS(CB)) out_bus ();

    antialiased_line_drawer #(
        .COORD_BITS(CB),
        .ACC_BITS  (AB)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // command words waiting to be driven, pixels waiting to come out
    line_word_t cmd_words[$];
    pixel_t     pending_pixels[$];
    line_word_t held;

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;   // no idling on either side while set

    // predictor copy of the registers
    logic [BASE_BITS-1:0]  base_color;
    logic [LEVEL_BITS-1:0] num_levels;
    logic [IBITS_BITS-1:0] ibits;

    // predictor copy of the line state
    int            cur_x, cur_y, end_x, end_y, steps_left;
    logic [AB-1:0] acc, acc_step;
    logic          go_left;
    line_kind_t    kind;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_pixel(int x, int y, logic [31:0] color, logic last,
                                        logic done, bit mute);
        pixel_t p;
        p.px    = (CB+1)'(x);
        p.py    = (CB+1)'(y);
        p.color = COLOR_BITS'(color);
        p.last  = last;
        p.done  = done;
        if (!mute) pending_pixels.push_back(p);
    endfunction

    // works out the pixels one accepted word draws and steps the line state
    task automatic trace_line(input line_word_t w, input bit mute);
        int            x0, y0, x1, y1, dx, dy, dir, t;
        logic [AB-1:0] prev;
        logic [31:0]   wt, cmask;
        int            sh;
        if (w.cmd == CMD_START) begin
            x0 = w.xs;
            y0 = w.ys;
            x1 = w.xe;
            y1 = w.ye;
            // order the endpoints top to bottom
            if (y0 > y1) begin
                t = y0; y0 = y1; y1 = t;
                t = x0; x0 = x1; x1 = t;
            end
            cur_x = x0;
            cur_y = y0;
            end_x = x1;
            end_y = y1;
            dx = x1 - x0;
            go_left = (dx < 0);
            if (dx < 0) dx = -dx;
            dy = y1 - y0;
            acc = '0;
            acc_step = '0;
            if (dy == 0) begin
                kind = (dx == 0) ? LN_IDLE : LN_HORIZ;
                steps_left = dx;
            end else if (dx == 0) begin
                kind = LN_VERT;
                steps_left = dy;
            end else if (dx == dy) begin
                kind = LN_DIAG;
                steps_left = dy;
            end else if (dy > dx) begin
                kind = LN_STEEP;
                steps_left = dy;
                acc_step = AB'((longint'(dx) << AB) / dy);
            end else begin
                kind = LN_SHALLOW;
                steps_left = dx;
                acc_step = AB'((longint'(dy) << AB) / dx);
            end
            queue_pixel(x0, y0, 32'(base_color), 1'b1, kind == LN_IDLE, mute);
        end else if (kind == LN_IDLE || steps_left == 0) begin
            kind = LN_IDLE;
        end else begin
            dir = go_left ? -1 : 1;
            if (kind == LN_HORIZ || kind == LN_VERT || kind == LN_DIAG) begin
                // straight lines: one unweighted pixel per advance
                if (kind != LN_VERT) cur_x += dir;
                if (kind != LN_HORIZ) cur_y += 1;
                steps_left--;
                queue_pixel(cur_x, cur_y, 32'(base_color), 1'b1, steps_left == 0, mute);
                if (steps_left == 0) kind = LN_IDLE;
            end else if (steps_left <= 1) begin
                // closing advance of a sloped line: far endpoint, unweighted
                steps_left = 0;
                kind = LN_IDLE;
                queue_pixel(end_x, end_y, 32'(base_color), 1'b1, 1'b1, mute);
            end else begin
                prev = acc;
                acc = acc + acc_step;
                sh = (ibits >= AB) ? 0 : AB - ibits;
                wt = 32'(acc) >> sh;
                cmask = (32'(num_levels) - 1) & 32'h1FF;
                // a wrap of the accumulator moves the minor axis one step
                if (kind == LN_STEEP) begin
                    if (acc <= prev) cur_x += dir;
                    cur_y += 1;
                    queue_pixel(cur_x, cur_y, 32'(base_color) + wt, 1'b0, 1'b0, mute);
                    queue_pixel(cur_x + dir, cur_y, 32'(base_color) + (wt ^ cmask),
                                1'b1, 1'b0, mute);
                end else begin
                    if (acc <= prev) cur_y += 1;
                    cur_x += dir;
                    queue_pixel(cur_x, cur_y, 32'(base_color) + wt, 1'b0, 1'b0, mute);
                    queue_pixel(cur_x, cur_y + 1, 32'(base_color) + (wt ^ cmask),
                                1'b1, 1'b0, mute);
                end
                steps_left--;
            end
        end
    endtask

    function automatic line_word_t row(check_t chk, logic c, int xs, int ys, int xe, int ye,
                                       int tx = 0, int ty = 0, logic td = 1'b0);
        line_word_t r;
        r.check  = chk;
        r.cmd    = c;
        r.xs     = CB'(xs);
        r.ys     = CB'(ys);
        r.xe     = CB'(xe);
        r.ye     = CB'(ye);
        r.tx     = (CB+1)'(tx);
        r.ty     = (CB+1)'(ty);
        r.tcolor = COLOR_BITS'(BASE_COLOR_RST);
        r.tdone  = td;
        return r;
    endfunction

    // mirror an endpoint that left the coordinate range back around the anchor
    function automatic int fold_coord(int anchor, int b);
        if (b > 2047 || b < -2048) return 2 * anchor - b;
        return b;
    endfunction

    function automatic int junk_coord();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    // random lines: mostly short ones run to the end (plus a few idle advances),
    // some abandoned by the next start, some straight, a few spanning the range
    task automatic plan_random_lines(input int target);
        int made, pick, x0, y0, x1, y1, len, major, adv, ax, ay;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            x0 = junk_coord();
            y0 = junk_coord();
            if (pick < 4) begin
                // stray advances, idle or tail of an abandoned line
                repeat ($urandom_range(1, 3))
                    cmd_words.push_back(row(CHK_MODEL, CMD_ADVANCE, junk_coord(), junk_coord(),
                                            junk_coord(), junk_coord()));
                continue;
            end else if (pick < 14) begin
                x1 = junk_coord();
                y1 = junk_coord();
            end else if (pick < 34) begin
                len = $urandom_range(0, 12);
                x1 = x0;
                y1 = y0;
                case ($urandom_range(0, 3))
                    0: x1 = x0 + ($urandom_range(0, 1) ? len : -len);
                    1: y1 = y0 + ($urandom_range(0, 1) ? len : -len);
                    2: begin
                        x1 = x0 + ($urandom_range(0, 1) ? len : -len);
                        y1 = y0 + ($urandom_range(0, 1) ? len : -len);
                    end
                    default: ;
                endcase
            end else begin
                x1 = x0 + $urandom_range(0, 48) - 24;
                y1 = y0 + $urandom_range(0, 48) - 24;
            end
            x1 = fold_coord(x0, x1);
            y1 = fold_coord(y0, y1);
            ax = (x1 > x0) ? x1 - x0 : x0 - x1;
            ay = (y1 > y0) ? y1 - y0 : y0 - y1;
            major = (ax > ay) ? ax : ay;
            if (major > 60) adv = $urandom_range(0, 30);
            else if ($urandom_range(0, 99) < 80) adv = major + $urandom_range(0, 2);
            else adv = $urandom_range(0, major);
            cmd_words.push_back(row(CHK_MODEL, CMD_START, x0, y0, x1, y1));
            repeat (adv)
                cmd_words.push_back(row(CHK_MODEL, CMD_ADVANCE, junk_coord(), junk_coord(),
                                        junk_coord(), junk_coord()));
            made += 1 + ((adv < major) ? adv : major);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BASE_COLOR:     base_color = BASE_BITS'(val);
            REG_NUM_LEVELS:     num_levels = LEVEL_BITS'(val);
            REG_INTENSITY_BITS: ibits      = IBITS_BITS'(val);
            default: ;
        endcase
    endtask

    // every word taken, every pixel seen, then room for a divider still running
    task automatic wait_drained();
        while (cmd_words.size() != 0 || in_bus.valid || pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // command side: a word is taken at an edge with valid and ready both high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                trace_line(held, held.check != CHK_MODEL);
                if (held.check == CHK_TYPED)
                    pending_pixels.push_back('{held.tx, held.ty, held.tcolor, 1'b1, held.tdone});
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (cmd_words.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held = cmd_words.pop_front();
                    in_bus.cmd     <= held.cmd;
                    in_bus.x_start <= held.xs;
                    in_bus.y_start <= held.ys;
                    in_bus.x_end   <= held.xe;
                    in_bus.y_end   <= held.ye;
                    in_bus.valid   <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // pixel side: random back-pressure, each taken pixel checked against the oldest expected
    always @(posedge i_clk) begin
        pixel_t want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel with none expected: x %0d y %0d", out_bus.pix_x, out_bus.pix_y);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (out_bus.pix_x !== want.px) begin
                        $error("pix_x: expected %0d, got %0d", want.px, out_bus.pix_x);
                        mismatches++;
                    end
                    if (out_bus.pix_y !== want.py) begin
                        $error("pix_y: expected %0d, got %0d", want.py, out_bus.pix_y);
                        mismatches++;
                    end
                    if (out_bus.pix_color !== want.color) begin
                        $error("pix_color: expected %0d, got %0d", want.color, out_bus.pix_color);
                        mismatches++;
                    end
                    if (out_bus.item_last !== want.last) begin
                        $error("item_last: expected %0d, got %0d", want.last, out_bus.item_last);
                        mismatches++;
                    end
                    if (out_bus.line_done !== want.done) begin
                        $error("line_done: expected %0d, got %0d", want.done, out_bus.line_done);
                        mismatches++;
                    end
                end
            end
            out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog: too long with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        line_word_t  probes [N_PROBES];
        int unsigned base_set [PHASES];
        int unsigned level_set [PHASES];
        int unsigned ibits_set [PHASES];

        in_bus.valid   = 1'b0;
        in_bus.cmd     = CMD_START;
        in_bus.x_start = '0;
        in_bus.y_start = '0;
        in_bus.x_end   = '0;
        in_bus.y_end   = '0;
        out_bus.ready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;

        base_color = BASE_COLOR_RST;
        num_levels = NUM_LEVELS_RST;
        ibits      = INTENSITY_BITS_RST;
        cur_x = 0; cur_y = 0; end_x = 0; end_y = 0; steps_left = 0;
        acc = '0; acc_step = '0; go_left = 1'b0; kind = LN_IDLE;

        // first setting keeps the reset values; then color wrap, the smallest ramp,
        // zero weight with a full mask, the most intensity bits, and two ordinary ramps
        base_set  = '{0, 255, 17, 0, 255, 100, 3};
        level_set = '{256, 256, 2, 0, 511, 16, 128};
        ibits_set = '{8, 8, 1, 0, 15, 4, 7};

        // directed lines under reset registers; the first pixel of a start is
        // the upper endpoint in the base color
        probes = '{
            // advance straight out of reset draws nothing
            row(CHK_NONE,  CMD_ADVANCE, 0, 0, 0, 0),
            // single point: one pixel that also ends the line
            row(CHK_TYPED, CMD_START, 5, -7, 5, -7, 5, -7, 1'b1),
            row(CHK_NONE,  CMD_ADVANCE, 0, 0, 0, 0),
            // full-range diagonal, then the same one given bottom first
            row(CHK_TYPED, CMD_START, -2048, -2048, 2047, 2047, -2048, -2048),
            row(CHK_MODEL, CMD_ADVANCE, 2047, 2047, -2048, -2048),
            row(CHK_TYPED, CMD_START, 2047, 2047, -2048, -2048, -2048, -2048),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            // steep line stepping left, abandoned by the next start
            row(CHK_TYPED, CMD_START, 0, 10, 3, 2, 3, 2),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            // widest shallow line
            row(CHK_TYPED, CMD_START, 2047, 0, -2048, 1, 2047, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            // horizontal along the bottom edge, vertical through the whole range
            row(CHK_TYPED, CMD_START, -2048, 2047, 2047, 2047, -2048, 2047),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_TYPED, CMD_START, -1, -2048, -1, 2047, -1, -2048),
            row(CHK_MODEL, CMD_ADVANCE, -1, -1, -1, -1),
            // short shallow line at the corner run to its end and one past
            row(CHK_TYPED, CMD_START, 2044, 2046, 2047, 2047, 2044, 2046),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0),
            row(CHK_MODEL, CMD_ADVANCE, 0, 0, 0, 0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_reg(REG_BASE_COLOR, base_set[p]);
                write_reg(REG_NUM_LEVELS, level_set[p]);
                write_reg(REG_INTENSITY_BITS, ibits_set[p]);
            end
            // one setting runs with both sides always willing
            steady = (p == 2);
            if (p == 0)
                for (int i = 0; i < N_PROBES; i++) cmd_words.push_back(probes[i]);
            plan_random_lines(WORDS_PER_PHASE);
            wait_drained();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ald_pkg.sv
rtl/ald_if.sv
rtl/ald_div.sv
rtl/antialiased_line_drawer.sv
rtl/ald_checker.sv
test/antialiased_line_drawer_tb.sv
